### design/kss_pkg.sv
package kss_pkg;

  // Store geometry
  localparam int unsigned SlotCount = 63;
  localparam int unsigned KeyWords  = 4;
  localparam int unsigned WordW     = 64;
  localparam int unsigned KeyW      = KeyWords * WordW;
  localparam int unsigned SlotW     = 6;
  localparam int unsigned OpW       = 2;
  localparam int unsigned StatusW   = 2;

  // Request codes; the fourth code is unused
  typedef enum logic [OpW-1:0] {
    OpRegister   = 2'd0,
    OpUnregister = 2'd1,
    OpRead       = 2'd2
  } op_e;

  // Response codes
  typedef enum logic [StatusW-1:0] {
    StOk     = 2'd0,
    StFull   = 2'd1,
    StAbsent = 2'd2
  } status_e;

  // Command from the allocator to the key memory
  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [SlotW-1:0] addr;
  } mem_cmd_t;

  // Registered response of one request
  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] granted;
    logic             show_key;
  } resp_t;

endpackage

### design/kss_alloc.sv
module kss_alloc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [kss_pkg::OpW-1:0]       operation_i,
  input  logic [kss_pkg::SlotW-1:0]     slot_i,
  output kss_pkg::mem_cmd_t             mem_cmd_o,
  output kss_pkg::resp_t                resp_o,
  output logic                          done_o
);

  logic [kss_pkg::SlotCount-1:0] valid_q, valid_d;
  kss_pkg::resp_t                resp_q, resp_d;
  logic                          done_q;
  logic [kss_pkg::SlotW-1:0]     free_idx;
  logic                          all_full;
  logic                          slot_in_range;
  logic                          slot_hit;

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = kss_pkg::SlotCount - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = kss_pkg::SlotW'(i);
      end
    end
  end

  assign all_full      = &valid_q;
  assign slot_in_range = (slot_i < kss_pkg::SlotW'(kss_pkg::SlotCount));
  assign slot_hit      = slot_in_range && valid_q[slot_i];

  // Request decode and bitmap update
  always_comb begin
    valid_d           = valid_q;
    resp_d.status     = kss_pkg::StAbsent;
    resp_d.granted    = '0;
    resp_d.show_key   = 1'b0;
    mem_cmd_o.wr_en   = 1'b0;
    mem_cmd_o.rd_en   = 1'b0;
    mem_cmd_o.addr    = slot_i;
    case (operation_i)
      kss_pkg::OpRegister: begin
        mem_cmd_o.addr = free_idx;
        if (all_full) begin
          resp_d.status = kss_pkg::StFull;
        end else begin
          resp_d.status     = kss_pkg::StOk;
          resp_d.granted    = free_idx;
          mem_cmd_o.wr_en   = accept_i;
          valid_d[free_idx] = 1'b1;
        end
      end
      kss_pkg::OpUnregister: begin
        if (slot_hit) begin
          resp_d.status   = kss_pkg::StOk;
          valid_d[slot_i] = 1'b0;
        end
      end
      kss_pkg::OpRead: begin
        if (slot_hit) begin
          resp_d.status   = kss_pkg::StOk;
          resp_d.show_key = 1'b1;
          mem_cmd_o.rd_en = accept_i;
        end
      end
      default: begin
        resp_d.status = kss_pkg::StAbsent;
      end
    endcase
  end

  // Bitmap and response registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept_i;
      if (accept_i) begin
        valid_q <= valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      resp_q <= resp_d;
    end
  end

  assign resp_o = resp_q;
  assign done_o = done_q;

endmodule

### design/kss_key_mem.sv
module kss_key_mem (
  input  logic                      clk_i,
  input  kss_pkg::mem_cmd_t         cmd_i,
  input  logic [kss_pkg::KeyW-1:0]  wdata_i,
  output logic [kss_pkg::KeyW-1:0]  rdata_o
);

  logic [kss_pkg::KeyW-1:0] mem_q [kss_pkg::SlotCount];
  logic [kss_pkg::KeyW-1:0] rdata_q;

  // One write or one read per cycle, registered read data
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.addr] <= wdata_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[cmd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/key_slot_store_top.sv
// Key slot store: 63 slots of 256-bit keys with an occupancy bitmap.
// The result beat is on the outputs, with done_o high, in the cycle
// after the request is taken. Throughput: one request per cycle; busy is
// never raised, as the bitmap is updated and the key memory read or written
// at the accepting edge. Reset clears the bitmap and the result strobe; the
// key memory is not cleared. The receiver cannot stall.
module key_slot_store_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [kss_pkg::OpW-1:0]      operation_i,
  input  logic [kss_pkg::SlotW-1:0]    slot_i,
  input  logic [kss_pkg::WordW-1:0]    key_word_0_i,
  input  logic [kss_pkg::WordW-1:0]    key_word_1_i,
  input  logic [kss_pkg::WordW-1:0]    key_word_2_i,
  input  logic [kss_pkg::WordW-1:0]    key_word_3_i,
  output logic                         done_o,
  output logic [kss_pkg::StatusW-1:0]  status_o,
  output logic [kss_pkg::SlotW-1:0]    granted_slot_o,
  output logic [kss_pkg::WordW-1:0]    read_word_0_o,
  output logic [kss_pkg::WordW-1:0]    read_word_1_o,
  output logic [kss_pkg::WordW-1:0]    read_word_2_o,
  output logic [kss_pkg::WordW-1:0]    read_word_3_o
);

  logic                            accept;
  kss_pkg::mem_cmd_t               mem_cmd;
  kss_pkg::resp_t                  resp;
  logic [3:0][kss_pkg::WordW-1:0]  key_in;
  logic [3:0][kss_pkg::WordW-1:0]  key_out;
  logic [kss_pkg::KeyW-1:0]        wdata;
  logic [kss_pkg::KeyW-1:0]        rdata;

  // Every request is taken at once
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign key_in = {key_word_3_i, key_word_2_i, key_word_1_i, key_word_0_i};

  // Pack the stored key words
  always_comb begin
    wdata = '0;
    for (int w = 0; w < kss_pkg::KeyWords; w++) begin
      wdata[w*kss_pkg::WordW +: kss_pkg::WordW] = key_in[w];
    end
  end

  kss_alloc u_alloc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .operation_i (operation_i),
    .slot_i      (slot_i),
    .mem_cmd_o   (mem_cmd),
    .resp_o      (resp),
    .done_o      (done_o)
  );

  kss_key_mem u_key_mem (
    .clk_i   (clk_i),
    .cmd_i   (mem_cmd),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // Read words only on a successful read, zero above the key length
  always_comb begin
    key_out = '0;
    for (int w = 0; w < 4; w++) begin
      if (w < kss_pkg::KeyWords && resp.show_key) begin
        key_out[w] = rdata[w*kss_pkg::WordW +: kss_pkg::WordW];
      end
    end
  end

  assign status_o       = resp.status;
  assign granted_slot_o = resp.granted;
  assign read_word_0_o  = key_out[0];
  assign read_word_1_o  = key_out[1];
  assign read_word_2_o  = key_out[2];
  assign read_word_3_o  = key_out[3];

  // Checks
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o) else $error("result beat missing after request");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept)) else $error("result beat without request");

  a_grant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (granted_slot_o < kss_pkg::SlotW'(kss_pkg::SlotCount)))
    else $error("granted slot out of range");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != kss_pkg::StOk) |->
      (granted_slot_o == '0 && read_word_0_o == '0 && read_word_3_o == '0))
    else $error("failed request returned data");

endmodule
